// ----- rtl/core/bia_pkg.sv -----
// shared constants and types of the bitmap id allocator
package bia_pkg;

	localparam int unsigned ID_COUNT      = 256;
	localparam int unsigned MAP_WORD_BITS = 32;
	localparam int unsigned MAP_WORDS     = (ID_COUNT + MAP_WORD_BITS - 1) / MAP_WORD_BITS;

	localparam int unsigned ID_W       = 8;
	localparam int unsigned BIT_IDX_W  = $clog2(MAP_WORD_BITS);
	localparam int unsigned WORD_IDX_W = ID_W - BIT_IDX_W;

	localparam logic [ID_W-1:0] TOP_MAX = ID_W'(ID_COUNT - 1);
	localparam logic [ID_W-1:0] HIGHEST_ID_RESET = ID_W'(255);

	// result status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_FULL     = 2'd1;
	localparam logic [1:0] ST_NOT_USED = 2'd2;

	// operation codes
	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	typedef logic [MAP_WORD_BITS-1:0] map_word_t;

	typedef struct packed {
		logic                 en;
		logic [BIT_IDX_W-1:0] lo;
		logic [BIT_IDX_W-1:0] hi;
	} ffs_req_t;

	typedef struct packed {
		logic                 found;
		logic [BIT_IDX_W-1:0] pos;
	} ffs_rsp_t;

endpackage

// ----- rtl/core/bia_ffs.sv -----
// find-first-free unit over one map word within a bit window
module bia_ffs
	import bia_pkg::*;
(
	input  map_word_t word,
	input  ffs_req_t  req,
	output ffs_rsp_t  rsp
);

	map_word_t mask_lo;
	map_word_t mask_hi;
	map_word_t cand;

	always_comb begin
		mask_lo = '1 << req.lo;
		mask_hi = '1 >> (BIT_IDX_W'(MAP_WORD_BITS - 1) - req.hi);
		cand    = ~word & mask_lo & mask_hi & {MAP_WORD_BITS{req.en}};
	end

	// lowest free bit wins
	always_comb begin
		rsp.found = |cand;
		rsp.pos   = '0;
		for (int i = MAP_WORD_BITS - 1; i >= 0; i--) begin
			if (cand[i]) begin
				rsp.pos = BIT_IDX_W'(i);
			end
		end
	end

endmodule

// ----- rtl/core/bitmap_id_allocator_core.sv -----
// bitmap id allocator: next-fit allocation and release of ids from a used-bit map
// Each input transaction is either an allocate or a free and returns exactly one
// result transaction. The used-bit map is held as 32-bit words in flops and is
// cleared by reset. An allocate scans the map one word per cycle through a single
// find-first-free unit, starting at the next-fit pointer and wrapping past the top
// id to zero, visiting 1 to 9 words with 256 ids. A free does one read-modify-write
// of a single word. Input stall is high from acceptance until the result has been
// handed to the output register; a finished result may wait there while the next
// transaction is already being worked on. highest_id may only be written while no
// transaction is in flight.
module bitmap_id_allocator_core
	import bia_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	// configuration
	input  logic            cfg_wr_en,
	input  logic [ID_W-1:0] cfg_wr_data,
	// request channel
	input  logic            in_valid,
	output logic            in_stall,
	input  logic            operation,
	input  logic [ID_W-1:0] free_id,
	// result channel
	output logic            out_valid,
	input  logic            out_stall,
	output logic [1:0]      status,
	output logic [ID_W-1:0] granted_id
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_FREE,
		S_SCAN,
		S_DONE
	} state_t;

	state_t state_q;

	map_word_t map_q [MAP_WORDS];

	logic [ID_W-1:0]       highest_id_q;
	logic [ID_W-1:0]       search_start_q;
	logic [ID_W-1:0]       start_q;      // effective scan start
	logic [ID_W-1:0]       top_q;        // clamped top id
	logic [ID_W-1:0]       fid_q;
	logic [WORD_IDX_W-1:0] widx_q;       // word under scan
	logic                  wrap_q;       // scanning the part below start
	logic [1:0]            res_status_q;
	logic [ID_W-1:0]       res_id_q;
	logic                  out_valid_q;
	logic [1:0]            status_q;
	logic [ID_W-1:0]       granted_id_q;

	logic                  in_fire;
	logic                  out_free;
	logic [ID_W-1:0]       top_now;
	logic [ID_W-1:0]       start_now;
	logic [WORD_IDX_W-1:0] start_w;
	logic [WORD_IDX_W-1:0] top_w;
	logic [WORD_IDX_W-1:0] fid_w;
	logic [WORD_IDX_W-1:0] rd_idx;
	logic                  at_start;
	logic                  at_top;
	logic                  fid_used;
	map_word_t             rd_word;
	ffs_req_t              ffs_req;
	ffs_rsp_t              ffs_rsp;
	logic [ID_W-1:0]       hit_id;

	assign in_stall   = (state_q != S_IDLE);
	assign in_fire    = in_valid && !in_stall;
	assign out_free   = !out_valid_q || !out_stall;
	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign granted_id = granted_id_q;

	// clamp the top id and pull an out-of-range pointer back to zero
	assign top_now   = (highest_id_q > TOP_MAX) ? TOP_MAX : highest_id_q;
	assign start_now = (search_start_q > top_now) ? '0 : search_start_q;

	assign start_w  = start_q[ID_W-1:BIT_IDX_W];
	assign top_w    = top_q[ID_W-1:BIT_IDX_W];
	assign fid_w    = fid_q[ID_W-1:BIT_IDX_W];
	assign at_start = (widx_q == start_w);
	assign at_top   = (widx_q == top_w);

	// single map read port, shared by scan and free
	assign rd_idx  = (state_q == S_FREE) ? fid_w : widx_q;
	assign rd_word = map_q[rd_idx];

	assign fid_used = (32'(fid_q) < ID_COUNT) && rd_word[fid_q[BIT_IDX_W-1:0]];

	// bit window of the current word: start..top first, then 0..start-1 after wrap
	always_comb begin
		ffs_req.en = 1'b1;
		ffs_req.lo = '0;
		ffs_req.hi = '1;
		if (wrap_q) begin
			if (at_start) begin
				ffs_req.en = (start_q[BIT_IDX_W-1:0] != '0);
				ffs_req.hi = start_q[BIT_IDX_W-1:0] - BIT_IDX_W'(1);
			end
		end else begin
			if (at_start) begin
				ffs_req.lo = start_q[BIT_IDX_W-1:0];
			end
			if (at_top) begin
				ffs_req.hi = top_q[BIT_IDX_W-1:0];
			end
		end
	end

	bia_ffs u_ffs (
		.word (rd_word),
		.req  (ffs_req),
		.rsp  (ffs_rsp)
	);

	assign hit_id = {widx_q, ffs_rsp.pos};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			highest_id_q   <= HIGHEST_ID_RESET;
			search_start_q <= '0;
			out_valid_q    <= 1'b0;
			wrap_q         <= 1'b0;
			for (int i = 0; i < MAP_WORDS; i++) begin
				map_q[i] <= '0;
			end
		end else begin
			if (cfg_wr_en) begin
				highest_id_q <= cfg_wr_data;
			end

			// result register drains unless a new result is loaded this cycle
			if (out_valid_q && !out_stall && (state_q != S_DONE)) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						fid_q   <= free_id;
						top_q   <= top_now;
						start_q <= start_now;
						widx_q  <= start_now[ID_W-1:BIT_IDX_W];
						wrap_q  <= 1'b0;
						state_q <= (operation == OP_FREE) ? S_FREE : S_SCAN;
					end
				end
				S_FREE: begin
					res_id_q <= '0;
					if (fid_used) begin
						map_q[rd_idx][fid_q[BIT_IDX_W-1:0]] <= 1'b0;
						if (fid_q < search_start_q) begin
							search_start_q <= fid_q;
						end
						res_status_q <= ST_OK;
					end else begin
						res_status_q <= ST_NOT_USED;
					end
					state_q <= S_DONE;
				end
				S_SCAN: begin
					if (ffs_rsp.found) begin
						map_q[rd_idx][ffs_rsp.pos] <= 1'b1;
						search_start_q <= (hit_id >= top_q) ? '0 : hit_id + ID_W'(1);
						res_status_q   <= ST_OK;
						res_id_q       <= hit_id;
						state_q        <= S_DONE;
					end else if (!wrap_q && at_top) begin
						if (start_q == '0) begin
							// nothing below the start to revisit
							search_start_q <= start_q;
							res_status_q   <= ST_FULL;
							res_id_q       <= '0;
							state_q        <= S_DONE;
						end else begin
							wrap_q <= 1'b1;
							widx_q <= '0;
						end
					end else if (wrap_q && at_start) begin
						search_start_q <= start_q;
						res_status_q   <= ST_FULL;
						res_id_q       <= '0;
						state_q        <= S_DONE;
					end else begin
						widx_q <= widx_q + WORD_IDX_W'(1);
					end
				end
				S_DONE: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						status_q     <= res_status_q;
						granted_id_q <= res_id_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- rtl/core/bia_checker.sv -----
// port-level checks of the bitmap id allocator, bound to the top level
module bia_checker
	import bia_pkg::*;
(
	input logic            clk,
	input logic            arst_n,
	input logic            in_valid,
	input logic            in_stall,
	input logic            out_valid,
	input logic            out_stall,
	input logic [1:0]      status,
	input logic [ID_W-1:0] granted_id
);

	// status is one of the three defined codes
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == ST_OK || status == ST_FULL || status == ST_NOT_USED))
		else $error("undefined status code");

	// a failed result never carries an id
	a_no_grant_on_error: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != ST_OK) |-> (granted_id == '0))
		else $error("granted id on failed result");

	// one transaction at a time: stall rises right after acceptance
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("second transaction accepted while busy");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(status) && $stable(granted_id)))
		else $error("stalled result changed");

endmodule

bind bitmap_id_allocator_core bia_checker u_bia_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.status     (status),
	.granted_id (granted_id)
);

// ----- test/tb_top.sv -----
// self-checking testbench of the bitmap id allocator core
module tb_top;
	import bia_pkg::*;

	// result fields of one transaction as the allocator should return them
	typedef struct packed {
		logic [1:0]      st;
		logic [ID_W-1:0] gid;
	} id_result_t;

	// one line of the directed stimulus: a request, or a write of highest_id
	typedef enum bit {ROW_TXN, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t       kind;
		logic            op;
		logic [ID_W-1:0] id;     // free_id of a request, or the highest_id value
		bit              typed;  // expected result written in the row
		logic [1:0]      st;
		logic [ID_W-1:0] gid;
	} dir_row_t;

	localparam int DIR_ROWS      = 23;
	localparam int PHASES        = 8;
	localparam int PHASE_ITEMS   = 50;
	localparam int LONG_HOLD     = 120;      // receiver hold-off that backs the block up
	localparam int SETTLE_CYCLES = 16;       // covers the longest allocate
	localparam int TAIL_CYCLES   = 40;
	localparam int TIMEOUT_TU    = 6000000;  // watchdog limit, in simulation time units
	localparam int REPORT_LIMIT  = 50;

	// directed part: error codes, full map, pointer above the top id,
	// freeing a used id above the top id, and the field extremes
	localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
		'{ROW_TXN, OP_FREE,  8'd0,   1'b1, ST_NOT_USED, 8'd0},
		'{ROW_TXN, OP_FREE,  8'd255, 1'b1, ST_NOT_USED, 8'd0},
		'{ROW_TXN, OP_ALLOC, 8'd0,   1'b1, ST_OK,       8'd0},
		'{ROW_TXN, OP_ALLOC, 8'd255, 1'b1, ST_OK,       8'd1},
		'{ROW_TXN, OP_FREE,  8'd0,   1'b1, ST_OK,       8'd0},
		'{ROW_TXN, OP_ALLOC, 8'd0,   1'b1, ST_OK,       8'd0},
		'{ROW_TXN, OP_ALLOC, 8'd0,   1'b1, ST_OK,       8'd2},
		'{ROW_CFG, OP_ALLOC, 8'd0,   1'b0, ST_OK,       8'd0},
		'{ROW_TXN, OP_ALLOC, 8'd0,   1'b1, ST_FULL,     8'd0},
		'{ROW_TXN, OP_FREE,  8'd1,   1'b1, ST_OK,       8'd0},
		'{ROW_TXN, OP_FREE,  8'd200, 1'b1, ST_NOT_USED, 8'd0},
		'{ROW_CFG, OP_ALLOC, 8'd3,   1'b0, ST_OK,       8'd0},
		'{ROW_TXN, OP_ALLOC, 8'd0,   1'b0, ST_OK,       8'd0},
		'{ROW_TXN, OP_ALLOC, 8'd0,   1'b0, ST_OK,       8'd0},
		'{ROW_TXN, OP_ALLOC, 8'd0,   1'b1, ST_FULL,     8'd0},
		'{ROW_TXN, OP_FREE,  8'd2,   1'b0, ST_OK,       8'd0},
		'{ROW_TXN, OP_ALLOC, 8'd0,   1'b0, ST_OK,       8'd0},
		'{ROW_CFG, OP_ALLOC, 8'd255, 1'b0, ST_OK,       8'd0},
		'{ROW_TXN, OP_ALLOC, 8'd0,   1'b0, ST_OK,       8'd0},
		'{ROW_TXN, OP_FREE,  8'd3,   1'b0, ST_OK,       8'd0},
		'{ROW_TXN, OP_ALLOC, 8'd0,   1'b0, ST_OK,       8'd0},
		'{ROW_TXN, OP_FREE,  8'd255, 1'b1, ST_NOT_USED, 8'd0},
		'{ROW_TXN, OP_ALLOC, 8'd255, 1'b0, ST_OK,       8'd0}
	};

	// dut ports; the driven inputs are known from time zero
	logic            clk         = 1'b0;
	logic            arst_n      = 1'b0;
	logic            cfg_wr_en   = 1'b0;
	logic [ID_W-1:0] cfg_wr_data = '0;
	logic            in_valid    = 1'b0;
	logic            in_stall;
	logic            operation   = OP_ALLOC;
	logic [ID_W-1:0] free_id     = '0;
	logic            out_valid;
	logic            out_stall   = 1'b0;
	logic [1:0]      status;
	logic [ID_W-1:0] granted_id;

	// predictor state: used-bit map, next-fit pointer, highest_id
	map_word_t       id_map [MAP_WORDS];
	logic [ID_W-1:0] next_ptr;
	logic [ID_W-1:0] model_highest;

	id_result_t pending_results [$];

	int error_count   = 0;
	int alloc_sent    = 0;
	int free_sent     = 0;
	int cfg_writes    = 0;
	int ok_seen       = 0;
	int full_seen     = 0;
	int not_used_seen = 0;

	// receiver control: no idling while calm, long hold-off on request
	bit calm      = 1'b0;
	int hold_req  = 0;
	int hold_done = 0;
	int hold_left = 0;

	bitmap_id_allocator_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.operation   (operation),
		.free_id     (free_id),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.granted_id  (granted_id)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// global watchdog
	initial begin
		#(TIMEOUT_TU);
		$display("timeout: %0d results still outstanding", pending_results.size());
		$display("Verification failed");
		$finish;
	end

	task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
		error_count++;
		if (error_count <= REPORT_LIMIT)
			$display("mismatch at %0t: %s, got %0d expected %0d", $time, what, got, want);
	endtask

	function automatic bit map_bit(int id);
		if (id >= ID_COUNT)
			return 1'b0;
		return id_map[id / MAP_WORD_BITS][id % MAP_WORD_BITS];
	endfunction

	// next-fit allocate or free against the predictor state
	function automatic id_result_t predict_txn(logic op, logic [ID_W-1:0] fid);
		id_result_t r;
		int top;
		int start;
		int id;
		bit found;
		r = '{ST_OK, '0};
		found = 1'b0;
		if (op == OP_ALLOC) begin
			top = (model_highest > TOP_MAX) ? int'(TOP_MAX) : int'(model_highest);
			start = int'(next_ptr);
			// pointer left above a lowered top id restarts at zero
			if (start > top)
				start = 0;
			for (int n = 0; n <= top && !found; n++) begin
				id = start + n;
				if (id > top)
					id -= top + 1;
				if (!map_bit(id)) begin
					id_map[id / MAP_WORD_BITS][id % MAP_WORD_BITS] = 1'b1;
					r.gid = ID_W'(id);
					next_ptr = (id >= top) ? '0 : ID_W'(id + 1);
					found = 1'b1;
				end
			end
			if (!found) begin
				r.st = ST_FULL;
				next_ptr = ID_W'(start);
			end
		end else begin
			id = int'(fid);
			if (!map_bit(id)) begin
				r.st = ST_NOT_USED;
			end else begin
				id_map[id / MAP_WORD_BITS][id % MAP_WORD_BITS] = 1'b0;
				if (fid < next_ptr)
					next_ptr = fid;
			end
		end
		return r;
	endfunction

	// pick a random id that the predictor holds as allocated
	function automatic bit pick_used_id(output logic [ID_W-1:0] fid);
		int used;
		int k;
		used = 0;
		fid = '0;
		for (int i = 0; i < ID_COUNT; i++)
			used += map_bit(i);
		if (used == 0)
			return 1'b0;
		k = $urandom_range(used - 1);
		for (int i = 0; i < ID_COUNT; i++) begin
			if (map_bit(i)) begin
				if (k == 0) begin
					fid = ID_W'(i);
					return 1'b1;
				end
				k--;
			end
		end
		return 1'b0;
	endfunction

	// offer one request and hold it until the block takes it
	task automatic send_txn(logic op, logic [ID_W-1:0] fid, bit typed, id_result_t typed_res);
		id_result_t r;
		in_valid  <= 1'b1;
		operation <= op;
		free_id   <= fid;
		do @(posedge clk); while (in_stall);
		r = predict_txn(op, fid);
		if (typed)
			r = typed_res;
		pending_results.push_back(r);
		if (op == OP_ALLOC)
			alloc_sent++;
		else
			free_sent++;
	endtask

	// occasional sender gap between transactions
	task automatic sender_gap();
		if (!calm && $urandom_range(99) < 6) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	// drain the block, let it settle, then write highest_id
	task automatic write_highest(logic [ID_W-1:0] value);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		model_highest = value;
		cfg_writes++;
	endtask

	// receiver: random stalls, one long hold-off when asked
	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_req != hold_done) begin
			hold_done <= hold_req;
			hold_left <= LONG_HOLD - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= calm ? 1'b0 : ($urandom_range(99) < 6);
		end
	end

	// compare each result transaction with the oldest pending one
	always @(posedge clk) begin : result_check
		id_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result with no pending request", {14'd0, status}, 16'hffff);
			end else begin
				want = pending_results.pop_front();
				if (status !== want.st)
					report_mismatch("status", {14'd0, status}, {14'd0, want.st});
				if (granted_id !== want.gid)
					report_mismatch("granted_id", {8'd0, granted_id}, {8'd0, want.gid});
				if (status == ST_OK)
					ok_seen++;
				else if (status == ST_FULL)
					full_seen++;
				else if (status == ST_NOT_USED)
					not_used_seen++;
			end
		end
	end

	// stimulus
	initial begin : stimulus
		logic [ID_W-1:0] phase_highest [PHASES];
		logic [ID_W-1:0] fid;
		logic            op;
		int              alloc_pct;
		dir_row_t        row;

		for (int w = 0; w < MAP_WORDS; w++)
			id_map[w] = '0;
		next_ptr      = '0;
		model_highest = HIGHEST_ID_RESET;

		// single reset at the start of the run
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed rows
		for (int i = 0; i < DIR_ROWS; i++) begin
			row = DIR_TABLE[i];
			if (row.kind == ROW_CFG) begin
				write_highest(row.id);
			end else begin
				sender_gap();
				send_txn(row.op, row.id, row.typed, '{row.st, row.gid});
			end
		end

		// random phases, each under its own highest_id
		phase_highest = '{8'd255, 8'd0, 8'd31, 8'd32, 8'd1, 8'd7, 8'd128, 8'd255};
		phase_highest[6] = ID_W'($urandom_range(2, 254));
		for (int p = 0; p < PHASES; p++) begin
			write_highest(phase_highest[p]);
			// phase 1 runs without idling on either side
			calm <= (p == 1);
			// phase 3 backs the block up behind a long receiver hold-off
			if (p == 3)
				hold_req <= hold_req + 1;
			alloc_pct = $urandom_range(40, 90);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				sender_gap();
				op  = ($urandom_range(99) < alloc_pct) ? OP_ALLOC : OP_FREE;
				fid = ID_W'($urandom_range(0, 255));
				// mostly release ids that are really allocated, the rest is noise
				if (op == OP_FREE && $urandom_range(99) < 80)
					void'(pick_used_id(fid));
				send_txn(op, fid, 1'b0, '{ST_OK, '0});
			end
		end
		calm <= 1'b0;

		// drain and let the block go quiet
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (pending_results.size() != 0)
			report_mismatch("results never returned", 16'(pending_results.size()), 16'd0);

		$display("covered %0d allocate and %0d free transactions under %0d highest_id writes",
			alloc_sent, free_sent, cfg_writes);
		$display("results: %0d granted or released, %0d map full, %0d freeing a free id",
			ok_seen, full_seen, not_used_seen);
		if (error_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/core/bia_pkg.sv
rtl/core/bia_ffs.sv
rtl/core/bitmap_id_allocator_core.sv
rtl/core/bia_checker.sv
test/tb_top.sv
